FILE: rtl/core/h264_picture_order_count_top_defines.svh
// Assertion macros shared by the picture order count RTL.
// Included by the modules that carry concurrent assertions; needs no other file.
`ifndef H264_PICTURE_ORDER_COUNT_TOP_DEFINES_SVH
`define H264_PICTURE_ORDER_COUNT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define H264_POC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define H264_POC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/h264_poc_pkg.sv
// Types and constants of the picture order count block.
// No dependencies; used by the interfaces and the top level of the block.
package h264_poc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POC_TYPE          = 3'd0,
        CFG_LOG2_MAX_LSB      = 3'd1,
        CFG_LOG2_MAX_FRAME    = 3'd2,
        CFG_CYCLE_LENGTH      = 3'd3,
        CFG_OFFSET_NON_REF    = 3'd4,
        CFG_OFFSET_TOP_BOTTOM = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OPC_COMPUTE     = 1'b0,
        OPC_TABLE_WRITE = 1'b1
    } t_opcode;

    localparam logic [1:0] POC_TYPE_ZERO = 2'd0;
    localparam logic [1:0] POC_TYPE_ONE  = 2'd1;

    typedef struct packed {
        logic               opcode;
        logic               is_idr;
        logic [1:0]         ref_idc;
        logic [15:0]        frame_number;
        logic               field_picture;
        logic               bottom_field;
        logic [15:0]        order_lsb;
        logic signed [31:0] delta_first;
        logic signed [31:0] delta_second;
        logic               mmco5_seen;
        logic [7:0]         table_index;
        logic signed [31:0] table_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] picture_order;
        logic signed [31:0] top_order;
        logic signed [31:0] bottom_order;
    } t_out_item;

    typedef struct packed {
        logic [15:0] prev_lsb;
        logic [31:0] prev_msb;
        logic [31:0] prev_ref_top;
        logic        prev_ref_is_bottom;
        logic        prev_ref_mmco5;
        logic [15:0] prev_frame_number;
        logic [31:0] prev_frame_offset;
    } t_ctx;

endpackage

FILE: rtl/core/h264_poc_if.sv
// Valid/ready channel interfaces for the slice input, the result output and
// the configuration write port. Depends on h264_poc_pkg.
interface h264_poc_in_if;
    import h264_poc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface h264_poc_out_if;
    import h264_poc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface h264_poc_cfg_if;
    import h264_poc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/h264_poc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module h264_poc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/h264_poc_div.sv
// Restoring serial divider, 32-bit dividend by 8-bit divisor, one bit per cycle.
// No dependencies; used by the top level for the offset cycle position.
module h264_poc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic [7:0]  o_remainder
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_step;
    logic [31:0] r_quo;
    logic [7:0]  r_rem;
    logic [7:0]  r_div;
    logic [8:0]  trial;
    logic [8:0]  trial_sub;
    logic        trial_ge;

    assign trial     = {r_rem, r_quo[31]};
    assign trial_ge  = trial >= {1'b0, r_div};
    assign trial_sub = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo  <= {r_quo[30:0], trial_ge};
                r_rem  <= trial_ge ? trial_sub[7:0] : trial[7:0];
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/core/h264_picture_order_count_top.sv
// H.264 picture order count unit, top level: control sequencer and datapath.
// Depends on h264_poc_pkg, the channel interfaces, h264_poc_ram and h264_poc_div.
//
// One slice header enters per beat on i_in; a compute beat yields one beat of
// picture, top and bottom order counts on o_out, a table write beat yields none.
// Configuration beats on i_cfg are always taken and must arrive while idle.
// The per-stream history (previous lsb, msb, reference marks, frame number and
// offset) lives in a one-entry context memory that is read when a slice is
// taken and written back when its result is formed; the type-1 offset table is
// a second memory of TABLE_DEPTH entries with a one-port sequential walk.
// From acceptance the sequencer steps through S_CTX and S_PREP, then S_T0 or
// S_T2 for types 0 and 2; type 1 goes through S_T1A and S_T1B, with the 32-step
// divider, the table walk over cycle_length entries, S_MUL and S_T1C when
// div_start is raised, then S_T1E and S_T1F; all end in S_PIC, S_WB and S_PUSH.
// One slice is in work at a time; i_in is ready again as soon as the result
// sits in the output register, so a stalled receiver holds one result while
// the next slice is computed, and further stalls hold the sequencer.
// Reset clears the configuration to zero and marks the history as zero; the
// offset table holds no defined values until written.
`include "h264_picture_order_count_top_defines.svh"
module h264_picture_order_count_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    h264_poc_in_if.sink   i_in,
    h264_poc_out_if.source o_out,
    h264_poc_cfg_if.sink  i_cfg
);
    import h264_poc_pkg::*;

    localparam int         TAW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [8:0] TBL_DEPTH_W = 9'(TABLE_DEPTH);
    localparam int         CTX_W       = $bits(t_ctx);

    typedef enum logic [4:0] {
        S_IDLE, S_CTX, S_PREP, S_T0, S_T2, S_T1A, S_T1B, S_DIV, S_WALK,
        S_MUL, S_T1C, S_T1E, S_T1F, S_PIC, S_WB, S_PUSH
    } t_state;

    t_state      r_state;
    logic [1:0]  r_cfg_poc_type;
    logic [3:0]  r_cfg_lsb_log2;
    logic [3:0]  r_cfg_fn_log2;
    logic [7:0]  r_cfg_cl;
    logic [31:0] r_cfg_non_ref;
    logic [31:0] r_cfg_top_bot;

    t_in_item    r_item;
    t_ctx        r_ctx;
    logic        r_ctx_valid;
    logic [15:0] r_lsb;
    logic [31:0] r_msb;
    logic [31:0] r_fno;
    logic [31:0] r_abs;
    logic [31:0] r_cnt;
    logic [7:0]  r_pos;
    logic [7:0]  r_idx;
    logic [7:0]  r_rd_idx;
    logic        r_issuing;
    logic        r_rd_vld;
    logic [31:0] r_cyc;
    logic [31:0] r_psum;
    logic [31:0] r_prod;
    logic [31:0] r_exp;
    logic [31:0] r_top;
    logic [31:0] r_bot;
    logic [31:0] r_pic;
    t_out_item   r_res;
    logic        r_out_valid;
    t_out_item   r_out;

    logic               in_acc;
    logic               is_ref;
    logic [31:0]        lsb_mod;
    logic signed [33:0] lsb_half;
    logic signed [33:0] prev_lsb_s;
    logic signed [33:0] lsb_diff;
    logic [31:0]        msb_base;
    logic [31:0]        n_msb;
    logic [31:0]        fn_mod;
    logic [31:0]        n_fno;
    logic [31:0]        fn_sum;
    logic [31:0]        t2_val;
    logic               abs_dec;
    logic [31:0]        div_dividend;
    logic               div_start;
    logic               div_done;
    logic [31:0]        div_quo;
    logic [7:0]         div_rem;
    logic [CTX_W-1:0]   ctx_rdata;
    logic               ctx_re;
    logic               ctx_we;
    t_ctx               n_ctx;
    logic               tbl_we;
    logic               tbl_re;
    logic [31:0]        tbl_rdata;
    logic [31:0]        tbl_val;
    logic [31:0]        pic_val;
    logic               out_free;

    assign in_acc   = i_in.valid && i_in.ready;
    assign is_ref   = r_item.ref_idc != 2'd0;
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        lsb_mod  = 32'd1 << ({1'b0, r_cfg_lsb_log2} + 5'd4);
        lsb_half = $signed({2'b00, 1'b0, lsb_mod[31:1]});
        fn_mod   = 32'd1 << ({1'b0, r_cfg_fn_log2} + 5'd4);

        if (r_item.is_idr) begin
            prev_lsb_s = '0;
            msb_base   = '0;
        end else if (r_ctx.prev_ref_mmco5) begin
            prev_lsb_s = r_ctx.prev_ref_is_bottom ? '0 :
                         $signed({{2{r_ctx.prev_ref_top[31]}}, r_ctx.prev_ref_top});
            msb_base   = '0;
        end else begin
            prev_lsb_s = $signed({18'd0, r_ctx.prev_lsb});
            msb_base   = r_ctx.prev_msb;
        end
        lsb_diff = $signed({18'd0, r_lsb}) - prev_lsb_s;
        if (lsb_diff <= -lsb_half) begin
            n_msb = msb_base + lsb_mod;
        end else if (lsb_diff > lsb_half) begin
            n_msb = msb_base - lsb_mod;
        end else begin
            n_msb = msb_base;
        end

        if (r_item.is_idr) begin
            n_fno = '0;
        end else if (r_ctx.prev_frame_number > r_item.frame_number) begin
            n_fno = r_ctx.prev_frame_offset + fn_mod;
        end else begin
            n_fno = r_ctx.prev_frame_offset;
        end

        fn_sum = r_fno + {16'd0, r_item.frame_number};
        if (r_item.is_idr) begin
            t2_val = '0;
        end else begin
            t2_val = {fn_sum[30:0], 1'b0} - {31'd0, !is_ref};
        end

        abs_dec      = !is_ref && (r_abs != 32'd0);
        div_dividend = r_abs - (abs_dec ? 32'd2 : 32'd1);

        tbl_val = ({1'b0, r_rd_idx} < TBL_DEPTH_W) ? tbl_rdata : 32'd0;

        if (r_item.field_picture) begin
            pic_val = r_item.bottom_field ? r_bot : r_top;
        end else begin
            pic_val = ($signed(r_bot) < $signed(r_top)) ? r_bot : r_top;
        end

        n_ctx = r_ctx;
        if (r_cfg_poc_type == POC_TYPE_ZERO) begin
            if (is_ref) begin
                n_ctx.prev_lsb           = r_lsb;
                n_ctx.prev_msb           = r_msb;
                n_ctx.prev_ref_is_bottom = r_item.field_picture && r_item.bottom_field;
                n_ctx.prev_ref_mmco5     = r_item.mmco5_seen;
                n_ctx.prev_ref_top       = r_item.mmco5_seen ? r_top - r_pic : r_top;
            end else if (r_item.is_idr) begin
                n_ctx.prev_lsb = '0;
                n_ctx.prev_msb = '0;
            end
        end else begin
            n_ctx.prev_frame_number = r_item.mmco5_seen ? 16'd0 : r_item.frame_number;
            n_ctx.prev_frame_offset = r_item.mmco5_seen ? 32'd0 : r_fno;
        end
    end

    assign ctx_re    = in_acc && (i_in.data.opcode == OPC_COMPUTE);
    assign ctx_we    = r_state == S_WB;
    assign tbl_we    = in_acc && (i_in.data.opcode == OPC_TABLE_WRITE) &&
                       ({1'b0, i_in.data.table_index} < TBL_DEPTH_W);
    assign tbl_re    = (r_state == S_WALK) && r_issuing;
    assign div_start = (r_state == S_T1B) && (r_abs != 32'd0) &&
                       !(abs_dec && r_abs == 32'd1);

    h264_poc_ram #(
        .WIDTH(CTX_W),
        .DEPTH(1)
    ) u_ctx_ram (
        .i_clk  (i_clk),
        .i_we   (ctx_we),
        .i_waddr(1'b0),
        .i_wdata(n_ctx),
        .i_re   (ctx_re),
        .i_raddr(1'b0),
        .o_rdata(ctx_rdata)
    );

    h264_poc_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_tbl_ram (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(i_in.data.table_index[TAW-1:0]),
        .i_wdata(i_in.data.table_value),
        .i_re   (tbl_re),
        .i_raddr(r_idx[TAW-1:0]),
        .o_rdata(tbl_rdata)
    );

    h264_poc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_cfg_cl),
        .o_done     (div_done),
        .o_quotient (div_quo),
        .o_remainder(div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cfg_poc_type <= '0;
            r_cfg_lsb_log2 <= '0;
            r_cfg_fn_log2  <= '0;
            r_cfg_cl       <= '0;
            r_cfg_non_ref  <= '0;
            r_cfg_top_bot  <= '0;
            r_ctx_valid    <= 1'b0;
            r_issuing      <= 1'b0;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_POC_TYPE:          r_cfg_poc_type <= i_cfg.data[1:0];
                    CFG_LOG2_MAX_LSB:      r_cfg_lsb_log2 <= i_cfg.data[3:0];
                    CFG_LOG2_MAX_FRAME:    r_cfg_fn_log2  <= i_cfg.data[3:0];
                    CFG_CYCLE_LENGTH:      r_cfg_cl       <= i_cfg.data[7:0];
                    CFG_OFFSET_NON_REF:    r_cfg_non_ref  <= i_cfg.data;
                    CFG_OFFSET_TOP_BOTTOM: r_cfg_top_bot  <= i_cfg.data;
                    default: ;
                endcase
            end

            if ((r_state == S_PUSH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item <= i_in.data;
                        if (i_in.data.opcode == OPC_COMPUTE) begin
                            r_state <= S_CTX;
                        end
                    end
                end
                S_CTX: begin
                    r_ctx   <= r_ctx_valid ? t_ctx'(ctx_rdata) : '0;
                    r_lsb   <= r_item.order_lsb & lsb_mod[15:0] - 16'd1 |
                               (lsb_mod[16] ? 16'hFFFF : 16'h0000) & r_item.order_lsb;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_msb <= n_msb;
                    r_fno <= n_fno;
                    if (r_cfg_poc_type == POC_TYPE_ZERO) begin
                        r_state <= S_T0;
                    end else if (r_cfg_poc_type == POC_TYPE_ONE) begin
                        r_state <= S_T1A;
                    end else begin
                        r_state <= S_T2;
                    end
                end
                S_T0: begin
                    r_top <= r_msb + {16'd0, r_lsb};
                    r_bot <= r_item.field_picture ? r_msb + {16'd0, r_lsb} :
                             r_msb + {16'd0, r_lsb} + r_item.delta_second;
                    r_state <= S_PIC;
                end
                S_T2: begin
                    r_top   <= t2_val;
                    r_bot   <= t2_val;
                    r_state <= S_PIC;
                end
                S_T1A: begin
                    r_abs   <= (r_cfg_cl != 8'd0) ? fn_sum : 32'd0;
                    r_state <= S_T1B;
                end
                S_T1B: begin
                    if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_exp   <= is_ref ? 32'd0 : r_cfg_non_ref;
                        r_state <= S_T1E;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_cnt     <= div_quo;
                        r_pos     <= div_rem;
                        r_idx     <= '0;
                        r_issuing <= 1'b1;
                        r_rd_vld  <= 1'b0;
                        r_cyc     <= '0;
                        r_psum    <= '0;
                        r_state   <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_issuing) begin
                        r_rd_idx <= r_idx;
                        if (r_idx == r_cfg_cl - 8'd1) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 8'd1;
                        end
                    end
                    r_rd_vld <= r_issuing;
                    if (r_rd_vld) begin
                        r_cyc <= r_cyc + tbl_val;
                        if (r_rd_idx <= r_pos) begin
                            r_psum <= r_psum + tbl_val;
                        end
                        if (r_rd_idx == r_cfg_cl - 8'd1) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= r_cnt * r_cyc;
                    r_state <= S_T1C;
                end
                S_T1C: begin
                    r_exp   <= r_prod + r_psum + (is_ref ? 32'd0 : r_cfg_non_ref);
                    r_state <= S_T1E;
                end
                S_T1E: begin
                    r_top   <= r_exp + r_item.delta_first;
                    r_bot   <= r_exp + r_cfg_top_bot + r_item.delta_first;
                    r_state <= S_T1F;
                end
                S_T1F: begin
                    if (!r_item.field_picture) begin
                        r_bot <= r_top + r_cfg_top_bot + r_item.delta_second;
                    end else if (r_item.bottom_field) begin
                        r_top <= r_bot;
                    end else begin
                        r_bot <= r_top;
                    end
                    r_state <= S_PIC;
                end
                S_PIC: begin
                    r_pic   <= pic_val;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_ctx_valid         <= 1'b1;
                    r_res.picture_order <= r_pic;
                    r_res.top_order     <= r_top;
                    r_res.bottom_order  <= r_bot;
                    r_state             <= S_PUSH;
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `H264_POC_ASSERT_NEXT(a_tbl_write_no_work, i_clk, i_rst_n,
        in_acc && (i_in.data.opcode == OPC_TABLE_WRITE), r_state == S_IDLE,
        "table write beat started a computation")
    `H264_POC_ASSERT_NOW(a_walk_in_cycle, i_clk, i_rst_n,
        r_issuing, (r_state == S_WALK) && (r_idx < r_cfg_cl),
        "offset table walk ran past the cycle length")
    `H264_POC_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n,
        div_done, r_state == S_DIV,
        "divider finished outside the division step")
    `H264_POC_ASSERT_NOW(a_out_from_push, i_clk, i_rst_n,
        $rose(r_out_valid), $past(r_state == S_PUSH),
        "result beat raised without a finished computation")

endmodule
